/* src/rt2d_pkg.sv */
`default_nettype none
package rt2d_pkg;

   // Field and datapath widths
   localparam int DATA_W = 32;          // Q16.16 fields
   localparam int FRAC_W = 16;          // fraction bits of the fields
   localparam int ACC_W  = 52;          // Q.32 rotation datapath, with headroom
   localparam int Z_W    = 34;          // Q.30 residual angle, signed

   // CORDIC stage count, 8..32
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_STAGES   = 32;
   localparam int CORDIC_USED  = (CORDIC_STEPS < MAX_STAGES) ? CORDIC_STEPS : MAX_STAGES;

   // Gain correction: K in Q.30, product taken down to Q.32
   localparam int GAIN_W     = 31;
   localparam int PROD_W     = DATA_W + GAIN_W;
   localparam int GAIN_SHIFT = 14;
   localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

   // Angle reduction: angle * 2^14 in Q.30, offset by pi plus 8192 turns so
   // that the value is non-negative, then restoring subtract of 2*pi << k
   localparam int ANG_SHIFT     = 14;
   localparam int RED_W         = 48;
   localparam int RED_STEPS     = 14;
   localparam int RED_PER_STAGE = 2;
   localparam int RED_STAGES    = RED_STEPS / RED_PER_STAGE;
   localparam logic [RED_W-1:0] TWO_PI_RED = 48'd6746518852;
   localparam logic [RED_W-1:0] RED_OFFSET = 48'd55270855695010;
   localparam logic signed [Z_W-1:0] PI_Z      = 34'sd3373259426;
   localparam logic signed [Z_W-1:0] HALF_PI_Z = 34'sd1686629713;

   // Pipeline stage map
   localparam int STG_MUL    = 0;
   localparam int STG_RED0   = 1;
   localparam int STG_QUAD   = STG_RED0 + RED_STAGES;
   localparam int STG_CORD0  = STG_QUAD + 1;
   localparam int NUM_STAGES = STG_CORD0 + CORDIC_USED;
   localparam int STG_LAST   = NUM_STAGES - 1;

   // Rounding and saturation
   localparam int Q_W = ACC_W - FRAC_W;
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 << (FRAC_W - 1));
   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Payload carried down the pipeline
   typedef struct packed {
      logic signed [ACC_W-1:0]  x;
      logic signed [ACC_W-1:0]  y;
      logic signed [Z_W-1:0]    z;
      logic        [RED_W-1:0]  turn;
      logic signed [DATA_W-1:0] sx;
      logic signed [DATA_W-1:0] sy;
   } pipe_type;

   // atan(2^-i) in Q.30, truncated
   function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
      logic signed [Z_W-1:0] a;
      case (idx)
         0:  a = 34'sd843314856;
         1:  a = 34'sd497837829;
         2:  a = 34'sd263043836;
         3:  a = 34'sd133525158;
         4:  a = 34'sd67021686;
         5:  a = 34'sd33543515;
         6:  a = 34'sd16775850;
         7:  a = 34'sd8388437;
         8:  a = 34'sd4194282;
         9:  a = 34'sd2097149;
         10: a = 34'sd1048575;
         11: a = 34'sd524287;
         12: a = 34'sd262143;
         13: a = 34'sd131071;
         14: a = 34'sd65535;
         15: a = 34'sd32767;
         16: a = 34'sd16383;
         17: a = 34'sd8191;
         18: a = 34'sd4095;
         19: a = 34'sd2047;
         20: a = 34'sd1023;
         21: a = 34'sd511;
         22: a = 34'sd255;
         23: a = 34'sd127;
         24: a = 34'sd63;
         25: a = 34'sd31;
         26: a = 34'sd15;
         27: a = 34'sd7;
         28: a = 34'sd3;
         29: a = 34'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

/* src/rt2d_req_if.sv */
`default_nettype none
interface rt2d_req_if;
   import rt2d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] point_x;
   logic signed [DATA_W-1:0] point_y;
   logic signed [DATA_W-1:0] angle;
   logic signed [DATA_W-1:0] shift_x;
   logic signed [DATA_W-1:0] shift_y;

   modport source (output valid, point_x, point_y, angle, shift_x, shift_y, input ready);
   modport sink   (input valid, point_x, point_y, angle, shift_x, shift_y, output ready);
endinterface
`default_nettype wire

/* src/rt2d_rsp_if.sv */
`default_nettype none
interface rt2d_rsp_if;
   import rt2d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_x;
   logic signed [DATA_W-1:0] result_y;
   logic                     overflow;

   modport source (output valid, result_x, result_y, overflow, input ready);
   modport sink   (input valid, result_x, result_y, overflow, output ready);
endinterface
`default_nettype wire

/* src/rigid_transform_2d_core.sv */
// Path from transfer in to result valid: gain multiply, 7 angle-reduction stages,
//   quadrant fold, 16 CORDIC stages, then round into the output register.
// Throughput: one transfer per cycle; each stage is a register with a valid bit.
// A stalled result holds the last stage; earlier stages keep moving while it is empty.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
`default_nettype none
module rigid_transform_2d_core (
   input  logic       clock,
   input  logic       reset,
   rt2d_req_if.sink   req_ch,
   rt2d_rsp_if.source rsp_ch
);
   import rt2d_pkg::*;

   pipe_type                pipe_ff [NUM_STAGES];
   pipe_type                pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff;
   logic                    advance;
   logic                    out_free;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [DATA_W-1:0] rsp_y_ff, rsp_y_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   // Add shift, round half up to Q16.16, saturate; returns {overflow, value}
   function automatic logic [DATA_W:0] round_sat(input logic signed [ACC_W-1:0] v,
                                                 input logic signed [DATA_W-1:0] s);
      logic signed [ACC_W-1:0]  sum;
      logic        [Q_W-1:0]    q;
      logic        [Q_W-DATA_W:0] hi;
      logic                     ovf;
      logic signed [DATA_W-1:0] val;
      sum = v + (ACC_W'(s) <<< FRAC_W) + RND_HALF;
      q   = sum[ACC_W-1:FRAC_W];
      hi  = q[Q_W-1:DATA_W-1];
      ovf = !((&hi) || !(|hi));
      if (!ovf) begin
         val = q[DATA_W-1:0];
      end else if (q[Q_W-1]) begin
         val = SAT_MIN;
      end else begin
         val = SAT_MAX;
      end
      return {ovf, val};
   endfunction

   // Flow control: the pipe moves when its last stage is empty or the output frees
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = !valid_ff[STG_LAST] || out_free;
   assign req_ch.ready = advance;

   // Stage 0: gain multiply and angle offset
   logic signed [PROD_W-1:0] prod_x;
   logic signed [PROD_W-1:0] prod_y;
   logic signed [RED_W:0]    turn_s;

   always_comb begin
      prod_x = $signed(req_ch.point_x) * GAIN_Q30;
      prod_y = $signed(req_ch.point_y) * GAIN_Q30;
      turn_s = ((RED_W+1)'(req_ch.angle) <<< ANG_SHIFT) + $signed({1'b0, RED_OFFSET});
      pipe_in[STG_MUL].x    = ACC_W'(prod_x >>> GAIN_SHIFT);
      pipe_in[STG_MUL].y    = ACC_W'(prod_y >>> GAIN_SHIFT);
      pipe_in[STG_MUL].z    = '0;
      pipe_in[STG_MUL].turn = turn_s[RED_W-1:0];
      pipe_in[STG_MUL].sx   = req_ch.shift_x;
      pipe_in[STG_MUL].sy   = req_ch.shift_y;
   end

   // Angle reduction: two restoring subtract steps per stage
   for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
      localparam int S = STG_RED0 + j;
      always_comb begin
         logic [RED_W-1:0] rem;
         rem = pipe_ff[S-1].turn;
         for (int k = 0; k < RED_PER_STAGE; k++) begin
            if (rem >= (TWO_PI_RED << (RED_STEPS - 1 - j * RED_PER_STAGE - k))) begin
               rem = rem - (TWO_PI_RED << (RED_STEPS - 1 - j * RED_PER_STAGE - k));
            end
         end
         pipe_in[S]      = pipe_ff[S-1];
         pipe_in[S].turn = rem;
      end
   end

   // Recenter to [-pi, pi) and fold outer quadrants by a quarter turn
   always_comb begin
      logic signed [Z_W-1:0] zr;
      zr = $signed({1'b0, pipe_ff[STG_QUAD-1].turn[Z_W-2:0]}) - PI_Z;
      pipe_in[STG_QUAD] = pipe_ff[STG_QUAD-1];
      if (zr > HALF_PI_Z) begin
         pipe_in[STG_QUAD].x = -pipe_ff[STG_QUAD-1].y;
         pipe_in[STG_QUAD].y = pipe_ff[STG_QUAD-1].x;
         pipe_in[STG_QUAD].z = zr - HALF_PI_Z;
      end else if (zr < -HALF_PI_Z) begin
         pipe_in[STG_QUAD].x = pipe_ff[STG_QUAD-1].y;
         pipe_in[STG_QUAD].y = -pipe_ff[STG_QUAD-1].x;
         pipe_in[STG_QUAD].z = zr + HALF_PI_Z;
      end else begin
         pipe_in[STG_QUAD].z = zr;
      end
   end

   // CORDIC rotation, one micro-rotation per stage
   for (genvar c = 0; c < CORDIC_USED; c++) begin : g_cordic
      localparam int S = STG_CORD0 + c;
      always_comb begin
         logic signed [ACC_W-1:0] dx;
         logic signed [ACC_W-1:0] dy;
         dx = pipe_ff[S-1].y >>> c;
         dy = pipe_ff[S-1].x >>> c;
         pipe_in[S] = pipe_ff[S-1];
         if (!pipe_ff[S-1].z[Z_W-1]) begin
            pipe_in[S].x = pipe_ff[S-1].x - dx;
            pipe_in[S].y = pipe_ff[S-1].y + dy;
            pipe_in[S].z = pipe_ff[S-1].z - atan_q30(c);
         end else begin
            pipe_in[S].x = pipe_ff[S-1].x + dx;
            pipe_in[S].y = pipe_ff[S-1].y - dy;
            pipe_in[S].z = pipe_ff[S-1].z + atan_q30(c);
         end
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
      end
   end

   // Translate, round and saturate into the output register
   always_comb begin
      logic [DATA_W:0] rx;
      logic [DATA_W:0] ry;
      rx = round_sat(pipe_ff[STG_LAST].x, pipe_ff[STG_LAST].sx);
      ry = round_sat(pipe_ff[STG_LAST].y, pipe_ff[STG_LAST].sy);
      rsp_x_in   = rx[DATA_W-1:0];
      rsp_y_in   = ry[DATA_W-1:0];
      rsp_ovf_in = rx[DATA_W] | ry[DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= valid_ff[STG_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_x_ff   <= rsp_x_in;
         rsp_y_ff   <= rsp_y_in;
         rsp_ovf_ff <= rsp_ovf_in;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.result_x = rsp_x_ff;
   assign rsp_ch.result_y = rsp_y_ff;
   assign rsp_ch.overflow = rsp_ovf_ff;

   // Checks
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STG_LAST] && !out_free |=> valid_ff[STG_LAST] && $stable(pipe_ff[STG_LAST].x))
      else $error("last stage changed while output stalled");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STG_QUAD-1] |-> pipe_ff[STG_QUAD-1].turn < TWO_PI_RED)
      else $error("angle reduction left a full turn");

   a_folded: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STG_QUAD] |-> (pipe_ff[STG_QUAD].z <= HALF_PI_Z) &&
                             (pipe_ff[STG_QUAD].z >= -HALF_PI_Z))
      else $error("folded angle outside quarter turn");

   a_ovf_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> (rsp_x_ff == SAT_MAX) || (rsp_x_ff == SAT_MIN) ||
                                      (rsp_y_ff == SAT_MAX) || (rsp_y_ff == SAT_MIN))
      else $error("overflow flag without a clamped result");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> valid_ff[STG_MUL])
      else $error("accepted transfer did not enter the pipe");

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
   import rt2d_pkg::*;

   // Q16.16 landmarks used by the directed items
   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
   localparam int ANG_QUARTER   = 51472;    // ~pi/4
   localparam int ANG_HALF_LO   = 102943;   // just under pi/2 after scaling
   localparam int ANG_HALF_HI   = 102944;   // just over pi/2
   localparam int ANG_PI_LO     = 205887;   // just under pi
   localparam int ANG_PI_HI     = 205888;   // just over pi, wraps to -pi side
   localparam int ANG_TURN      = 411775;   // ~2*pi
   localparam int RANDOM_ITEMS  = 1628;
   localparam int DRAIN_CYCLES  = 60;

   // Idle behavior of either side
   typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_BURSTY} idle_mode_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] point_x;
      logic signed [DATA_W-1:0] point_y;
      logic signed [DATA_W-1:0] angle;
      logic signed [DATA_W-1:0] shift_x;
      logic signed [DATA_W-1:0] shift_y;
   } xform_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_x;
      logic signed [DATA_W-1:0] result_y;
      logic                     overflow;
   } xform_rsp_type;

   // Predicts each transform and checks results in order
   class xform_scoreboard_type;
      localparam longint TWO_PI_Q30  = 64'sd6746518852;
      localparam longint PI_Q30      = 64'sd3373259426;
      localparam longint HALF_PI_Q30 = 64'sd1686629713;
      localparam longint GAIN_K      = 64'sd652032874;

      longint        atan_tbl [32];
      xform_rsp_type pending_q [$];
      int            errors;
      int            checked;
      int            saturated;

      function new();
         atan_tbl = '{843314856, 497837829, 263043836, 133525158,
                      67021686, 33543515, 16775850, 8388437,
                      4194282, 2097149, 1048575, 524287,
                      262143, 131071, 65535, 32767,
                      16383, 8191, 4095, 2047,
                      1023, 511, 255, 127,
                      63, 31, 15, 7,
                      3, 1, 0, 0};
         errors    = 0;
         checked   = 0;
         saturated = 0;
      endfunction

      // Add translation, round half up to Q16.16 and clamp
      function void round_to_q16(input longint v, input longint s, inout bit hit,
                                 output logic signed [DATA_W-1:0] q);
         longint r;
         r = (v + s * 65536 + 32768) >>> 16;
         if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            hit = 1'b1;
         end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            hit = 1'b1;
         end
         q = r[31:0];
      endfunction

      function xform_rsp_type transform_point(xform_req_type r);
         longint        x, y, z, tmp, dx, dy;
         bit            hit;
         xform_rsp_type q;
         hit = 1'b0;
         // Angle reduction into [-pi, pi) in Q.30
         z = (longint'(r.angle) * 16384 + PI_Q30) % TWO_PI_Q30;
         if (z < 0)
            z += TWO_PI_Q30;
         z -= PI_Q30;
         // Gain pre-correction to Q.32
         x = (longint'(r.point_x) * GAIN_K) >>> 14;
         y = (longint'(r.point_y) * GAIN_K) >>> 14;
         // Quadrant fold
         if (z > HALF_PI_Q30) begin
            tmp = x;
            x   = -y;
            y   = tmp;
            z  -= HALF_PI_Q30;
         end else if (z < -HALF_PI_Q30) begin
            tmp = x;
            x   = y;
            y   = -tmp;
            z  += HALF_PI_Q30;
         end
         // Rotation stages
         for (int i = 0; i < CORDIC_USED; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= atan_tbl[i];
            end else begin
               x += dx;
               y -= dy;
               z += atan_tbl[i];
            end
         end
         round_to_q16(x, longint'(r.shift_x), hit, q.result_x);
         round_to_q16(y, longint'(r.shift_y), hit, q.result_y);
         q.overflow = hit;
         return q;
      endfunction

      function void note_input(xform_req_type r);
         pending_q.push_back(transform_point(r));
      endfunction

      function void check_result(xform_rsp_type got);
         xform_rsp_type want;
         if (pending_q.size() == 0) begin
            $error("result with no transform outstanding: x=%0d y=%0d ovf=%0b",
                   got.result_x, got.result_y, got.overflow);
            errors++;
            return;
         end
         want = pending_q.pop_front();
         checked++;
         if (want.overflow)
            saturated++;
         if (got.result_x !== want.result_x) begin
            $error("result_x: expected %0d, got %0d", want.result_x, got.result_x);
            errors++;
         end
         if (got.result_y !== want.result_y) begin
            $error("result_y: expected %0d, got %0d", want.result_y, got.result_y);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rt2d_req_if req_if ();
   rt2d_rsp_if rsp_if ();

   rigid_transform_2d_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   xform_scoreboard_type sb = new();
   idle_mode_type        send_mode = IDLE_NONE;
   int                   sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // No gap in IDLE_NONE; otherwise mostly short gaps, now and then a long one
   function automatic int pick_gap(idle_mode_type mode);
      if (mode == IDLE_NONE)
         return 0;
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(8, 40);
      if (mode == IDLE_SHORT)
         return $urandom_range(0, 2);
      return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
   endfunction

   function automatic idle_mode_type pick_mode();
      case ($urandom_range(0, 2))
         0: return IDLE_NONE;
         1: return IDLE_SHORT;
         default: return IDLE_BURSTY;
      endcase
   endfunction

   // Random coordinate: full range, mid range or near the origin
   function automatic logic signed [DATA_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
         default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
   endfunction

   // Random angle: full range, a few turns, or close to a quadrant boundary
   function automatic logic signed [DATA_W-1:0] rand_angle();
      int k;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return int'($urandom_range(0, 4 * ANG_TURN)) - 2 * ANG_TURN;
         2: begin
            k = int'($urandom_range(0, 8)) - 4;
            return k * ANG_HALF_HI + int'($urandom_range(0, 16)) - 8;
         end
         default: return int'($urandom_range(0, 2 * ANG_TURN)) - ANG_TURN;
      endcase
   endfunction

   // One transfer on the request channel, then an optional gap
   task automatic send_xform(input logic signed [DATA_W-1:0] px, py, ang, sx, sy);
      int gap;
      req_if.valid   <= 1'b1;
      req_if.point_x <= px;
      req_if.point_y <= py;
      req_if.angle   <= ang;
      req_if.shift_x <= sx;
      req_if.shift_y <= sy;
      do
         @(posedge clock);
      while (!req_if.ready);
      sent++;
      gap = pick_gap(send_mode);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Monitor both channels at the clock edge
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_input('{req_if.point_x, req_if.point_y, req_if.angle,
                         req_if.shift_x, req_if.shift_y});
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result('{rsp_if.result_x, rsp_if.result_y, rsp_if.overflow});
   end

   // Result-side back pressure
   initial begin : rsp_backpressure
      idle_mode_type mode;
      int            stall;
      int            rounds;
      mode   = IDLE_NONE;
      rounds = 0;
      rsp_if.ready = 1'b0;
      forever begin
         if (rounds % 40 == 0)
            mode = pick_mode();
         rounds++;
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         stall = pick_gap(mode);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int directed_cnt;
      int drain;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.point_x = '0;
      req_if.point_y = '0;
      req_if.angle   = '0;
      req_if.shift_x = '0;
      req_if.shift_y = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, quadrant and wrap edges, saturation both ways
      send_xform(0, 0, 0, 0, 0);
      send_xform(Q_ONE, 0, 0, 0, 0);
      send_xform(Q_ONE, 0, ANG_HALF_LO, 0, 0);
      send_xform(Q_ONE, 0, ANG_HALF_HI, 0, 0);
      send_xform(Q_ONE, Q_ONE, -ANG_HALF_LO, 0, 0);
      send_xform(Q_ONE, Q_ONE, -ANG_HALF_HI, 0, 0);
      send_xform(Q_ONE, -Q_ONE, ANG_PI_LO, 0, 0);
      send_xform(Q_ONE, -Q_ONE, ANG_PI_HI, 0, 0);
      send_xform(-Q_ONE, Q_ONE, -ANG_PI_LO, 0, 0);
      send_xform(-Q_ONE, Q_ONE, -ANG_PI_HI, 0, 0);
      send_xform(Q_MAX, Q_MAX, 0, 0, 0);
      send_xform(Q_MIN, Q_MIN, 0, 0, 0);
      send_xform(Q_MIN, 0, ANG_PI_LO, 0, 0);
      send_xform(Q_MAX, Q_MIN, ANG_QUARTER, 0, 0);
      send_xform(0, 0, Q_MAX, Q_MAX, Q_MIN);
      send_xform(0, 0, Q_MIN, Q_MIN, Q_MAX);
      send_xform(Q_ONE, Q_ONE, 0, Q_MAX, Q_MAX);
      send_xform(-Q_ONE, -Q_ONE, 0, Q_MIN, Q_MIN);
      send_xform(Q_MAX, 0, Q_MAX, Q_MAX, 0);
      send_xform(3 * Q_ONE, -2 * Q_ONE, ANG_TURN, Q_ONE, -Q_ONE);
      send_xform(-1, -1, -1, -1, -1);
      send_xform(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
                 32'sh55555555);
      directed_cnt = sent;

      // Random transforms, idle behavior changing every so often
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            send_mode = pick_mode();
         send_xform(rand_coord(), rand_coord(), rand_angle(), rand_coord(), rand_coord());
      end
      req_if.valid <= 1'b0;

      // Drain everything outstanding, then let the pipe idle before the summary
      while (sb.outstanding() != 0)
         @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++)
         @(posedge clock);

      $display("Covered %0d transforms (%0d directed, %0d random); %0d results checked,",
               sent, directed_cnt, sent - directed_cnt, sb.checked);
      $display("%0d of them saturated, under random gaps and back pressure.", sb.saturated);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("[rigid_transform_2d_core] OK");
      end else begin
         $display("[rigid_transform_2d_core] ERROR");
      end
      $finish;
   end

   // Hard stop for a hung run
   initial begin : watchdog
      #2_000_000;
      $display("timeout: %0d transforms still outstanding", sb.outstanding());
      $display("[rigid_transform_2d_core] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
